### hdl/n21rs_pkg.sv
// shared constants, widths, codes and controller/datapath interface types
package n21rs_pkg;

    localparam int MAX_SRC_WIDTH  = 640;
    localparam int MAX_SRC_HEIGHT = 480;
    localparam int MAX_DST_WIDTH  = 640;
    localparam int MAX_DST_HEIGHT = 480;

    localparam int SW_W  = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SH_W  = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DW_W  = $clog2(MAX_DST_WIDTH + 1);
    localparam int DH_W  = $clog2(MAX_DST_HEIGHT + 1);
    localparam int COL_W = DW_W;
    localparam int ROW_W = DH_W;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT
                                 + (MAX_SRC_WIDTH * MAX_SRC_HEIGHT) / 2;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int POS_W  = $clog2(STORE_DEPTH + 1);
    localparam int AREA_W = SW_W + SH_W;

    localparam int DIV_N_W = (COL_W + SW_W > ROW_W + SH_W) ? COL_W + SW_W : ROW_W + SH_W;
    localparam int DIV_D_W = (DW_W > DH_W) ? DW_W : DH_W;

    localparam int CFG_SW_W   = 10;
    localparam int CFG_SH_W   = 9;
    localparam int CFG_DW_W   = 10;
    localparam int CFG_DH_W   = 9;
    localparam int MEAN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_RED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_GREEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_BLUE  = 3'd6;

    localparam int BYTE_W  = 8;
    localparam int PIX_W   = 19;
    localparam int CH_W    = 17;
    localparam int TDATA_W = ((PIX_W + 3 * CH_W + 7) / 8) * 8;

    localparam int ACC_W   = 27;
    localparam int COEF_RV = 89831;
    localparam int COEF_GU = 45744;
    localparam int COEF_GV = 46080;
    localparam int COEF_BU = 113538;

    localparam int RD_SEL_W = 2;
    localparam logic [RD_SEL_W-1:0] RD_SEL_Y = 2'd0;
    localparam logic [RD_SEL_W-1:0] RD_SEL_V = 2'd1;
    localparam logic [RD_SEL_W-1:0] RD_SEL_U = 2'd2;

    typedef struct packed {
        logic                capture;
        logic                load_write;
        logic                wrap;
        logic                divx_start;
        logic                divy_start;
        logic                cap_sx;
        logic                cap_sy;
        logic                addr_calc;
        logic [RD_SEL_W-1:0] rd_sel;
        logic                cap_y;
        logic                cap_v;
        logic                prod;
        logic                conv;
        logic                emit;
        logic                emit_zero;
    } n21rs_cmd_t;

    typedef struct packed {
        logic action;
        logic incomplete;
        logic last;
        logic div_done;
    } n21rs_sts_t;

endpackage

### hdl/nv21_resize_to_planar_rgb_top.sv
// top level of the nv21 to planar rgb nearest-neighbor resizer
//
// The block takes one item at a time. A load item (tuser 0) writes the next
// NV21 byte into the on-chip frame store, Y plane first, then the interleaved
// V,U plane; bytes past the frame size are dropped. A convert item (tuser 1)
// returns the next target pixel in raster order as Q8.8 red, green and blue
// minus the programmed means, with tlast on the final pixel, after which the
// next frame must be loaded. A convert sent before the frame is fully loaded
// returns zeros with the frame_incomplete flag in tuser. For a convert, the
// source x and y coordinates come one after the other from one shared
// bit-serial divider, followed by three reads through the single read port of
// the frame store and a two stage color conversion. A finished pixel waits
// in the output register while the next item is already accepted. The frame
// store holds nothing meaningful after reset until a frame is loaded; no
// clearing pass is run. Configuration writes are taken every cycle and
// must only happen while the block is idle.
module nv21_resize_to_planar_rgb_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: frame_byte[7:0]
    input  logic [n21rs_pkg::BYTE_W-1:0]      s_tdata,
    // s_tuser: action[0]
    input  logic                              s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: pixel_index[18:0], red_value[35:19], green_value[52:36],
    // blue_value[69:53], zero pad[71:70]
    output logic [n21rs_pkg::TDATA_W-1:0]     m_tdata,
    // m_tuser: frame_incomplete[0]
    output logic                              m_tuser,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [n21rs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [n21rs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    n21rs_pkg::n21rs_cmd_t cmd;
    n21rs_pkg::n21rs_sts_t sts;

    assign cfg_ready = 1'b1;

    n21rs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    n21rs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

### hdl/n21rs_div.sv
// radix-2 restoring divider for the source coordinate scaling
module n21rs_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [n21rs_pkg::DIV_N_W-1:0]  dividend,
    input  logic [n21rs_pkg::DIV_D_W-1:0]  divisor,
    output logic                           done,
    output logic [n21rs_pkg::DIV_N_W-1:0]  quotient
);

    localparam int N_W   = n21rs_pkg::DIV_N_W;
    localparam int D_W   = n21rs_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   den_reg, den_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_next = {quo_reg[N_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/n21rs_dp.sv
// datapath: registers, frame store, coordinate scaling and color conversion
module n21rs_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tuser,
    input  logic [n21rs_pkg::BYTE_W-1:0]      s_tdata,
    input  logic                              cfg_valid,
    input  logic [n21rs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [n21rs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  n21rs_pkg::n21rs_cmd_t             cmd,
    output n21rs_pkg::n21rs_sts_t             sts,
    output logic [n21rs_pkg::TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    localparam int SW_W    = n21rs_pkg::SW_W;
    localparam int SH_W    = n21rs_pkg::SH_W;
    localparam int DW_W    = n21rs_pkg::DW_W;
    localparam int DH_W    = n21rs_pkg::DH_W;
    localparam int COL_W   = n21rs_pkg::COL_W;
    localparam int ROW_W   = n21rs_pkg::ROW_W;
    localparam int ADDR_W  = n21rs_pkg::ADDR_W;
    localparam int POS_W   = n21rs_pkg::POS_W;
    localparam int AREA_W  = n21rs_pkg::AREA_W;
    localparam int N_W     = n21rs_pkg::DIV_N_W;
    localparam int D_W     = n21rs_pkg::DIV_D_W;
    localparam int ACC_W   = n21rs_pkg::ACC_W;
    localparam int CH_W    = n21rs_pkg::CH_W;
    localparam int PIX_W   = n21rs_pkg::PIX_W;
    localparam int MEAN_W  = n21rs_pkg::MEAN_W;
    localparam int BYTE_W  = n21rs_pkg::BYTE_W;
    localparam int TDATA_W = n21rs_pkg::TDATA_W;
    localparam int Q_W     = ACC_W - 16;
    localparam int PAD_W   = TDATA_W - PIX_W - 3 * CH_W;

    function automatic logic [7:0] to_channel(input logic signed [ACC_W-1:0] acc);
        logic signed [Q_W-1:0] q;
        q = acc[ACC_W-1:16];
        if (q < 0)
            return 8'd0;
        else if (q > 255)
            return 8'd255;
        else
            return q[7:0];
    endfunction

    function automatic logic [CH_W-1:0] minus_mean(input logic [7:0] ch,
                                                   input logic [MEAN_W-1:0] mean);
        return {1'b0, ch, 8'h00} - {1'b0, mean};
    endfunction

    // configuration
    logic [n21rs_pkg::CFG_SW_W-1:0] src_width_reg;
    logic [n21rs_pkg::CFG_SH_W-1:0] src_height_reg;
    logic [n21rs_pkg::CFG_DW_W-1:0] dst_width_reg;
    logic [n21rs_pkg::CFG_DH_W-1:0] dst_height_reg;
    logic [MEAN_W-1:0]              mean_red_reg;
    logic [MEAN_W-1:0]              mean_green_reg;
    logic [MEAN_W-1:0]              mean_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 10'd640;
            src_height_reg <= 9'd480;
            dst_width_reg  <= 10'd224;
            dst_height_reg <= 9'd224;
            mean_red_reg   <= '0;
            mean_green_reg <= '0;
            mean_blue_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                n21rs_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[n21rs_pkg::CFG_SW_W-1:0];
                n21rs_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[n21rs_pkg::CFG_SH_W-1:0];
                n21rs_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data[n21rs_pkg::CFG_DW_W-1:0];
                n21rs_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data[n21rs_pkg::CFG_DH_W-1:0];
                n21rs_pkg::REG_MEAN_RED:   mean_red_reg   <= cfg_data[MEAN_W-1:0];
                n21rs_pkg::REG_MEAN_GREEN: mean_green_reg <= cfg_data[MEAN_W-1:0];
                n21rs_pkg::REG_MEAN_BLUE:  mean_blue_reg  <= cfg_data[MEAN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [SW_W-1:0] eff_sw;
    logic [SH_W-1:0] eff_sh;
    logic [DW_W-1:0] eff_dw;
    logic [DH_W-1:0] eff_dh;

    always_comb
    begin
        if (src_width_reg < 2)
            eff_sw = SW_W'(2);
        else if (src_width_reg > n21rs_pkg::MAX_SRC_WIDTH)
            eff_sw = SW_W'(n21rs_pkg::MAX_SRC_WIDTH);
        else
            eff_sw = SW_W'(src_width_reg);
        eff_sw[0] = 1'b0;

        if (src_height_reg < 2)
            eff_sh = SH_W'(2);
        else if (src_height_reg > n21rs_pkg::MAX_SRC_HEIGHT)
            eff_sh = SH_W'(n21rs_pkg::MAX_SRC_HEIGHT);
        else
            eff_sh = SH_W'(src_height_reg);
        eff_sh[0] = 1'b0;

        if (dst_width_reg < 1)
            eff_dw = DW_W'(1);
        else if (dst_width_reg > n21rs_pkg::MAX_DST_WIDTH)
            eff_dw = DW_W'(n21rs_pkg::MAX_DST_WIDTH);
        else
            eff_dw = DW_W'(dst_width_reg);

        if (dst_height_reg < 1)
            eff_dh = DH_W'(1);
        else if (dst_height_reg > n21rs_pkg::MAX_DST_HEIGHT)
            eff_dh = DH_W'(n21rs_pkg::MAX_DST_HEIGHT);
        else
            eff_dh = DH_W'(dst_height_reg);
    end

    // frame area and size, registered every cycle
    logic [AREA_W-1:0] area_mul;
    logic [AREA_W:0]   fsize_sum;
    logic [AREA_W-1:0] area_reg;
    logic [POS_W-1:0]  fsize_reg;

    assign area_mul  = eff_sw * eff_sh;
    assign fsize_sum = {1'b0, area_mul} + {2'b00, area_mul[AREA_W-1:1]};

    always_ff @(posedge clk)
    begin
        area_reg  <= area_mul;
        fsize_reg <= POS_W'(fsize_sum);
    end

    // input capture and positions
    logic              action_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [POS_W-1:0]  load_pos_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic              need_wrap;
    logic [ROW_W-1:0]  row_w;
    logic [COL_W-1:0]  col_w;
    logic [COL_W:0]    col_plus;
    logic              last;

    assign need_wrap = (row_reg >= eff_dh) || (col_reg >= eff_dw);
    assign row_w     = need_wrap ? '0 : row_reg;
    assign col_w     = need_wrap ? '0 : col_reg;
    assign col_plus  = {1'b0, col_reg} + 1'b1;
    assign last      = (row_reg == eff_dh - 1'b1) && (col_reg == eff_dw - 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= s_tuser;
            byte_reg   <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            if (cmd.load_write)
                load_pos_reg <= load_pos_reg + 1'b1;
            if (cmd.wrap)
            begin
                row_reg <= row_w;
                col_reg <= col_w;
            end
            else if (cmd.emit)
            begin
                if (last)
                begin
                    row_reg      <= '0;
                    col_reg      <= '0;
                    load_pos_reg <= '0;
                end
                else if (col_plus >= {1'b0, eff_dw})
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_plus[COL_W-1:0];
                end
            end
        end
    end

    // source coordinate scaling
    logic [COL_W+SW_W-1:0] mulx;
    logic [ROW_W+SH_W-1:0] muly;
    logic                  div_start;
    logic [N_W-1:0]        div_dividend;
    logic [D_W-1:0]        div_divisor;
    logic                  div_done;
    logic [N_W-1:0]        div_quotient;
    logic [SW_W-1:0]       sx_reg;
    logic [SH_W-1:0]       sy_reg;

    assign mulx         = col_w * eff_sw;
    assign muly         = row_reg * eff_sh;
    assign div_start    = cmd.divx_start | cmd.divy_start;
    assign div_dividend = cmd.divx_start ? N_W'(mulx) : N_W'(muly);
    assign div_divisor  = cmd.divx_start ? D_W'(eff_dw) : D_W'(eff_dh);

    n21rs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap_sx)
            sx_reg <= div_quotient[SW_W-1:0];
        if (cmd.cap_sy)
            sy_reg <= div_quotient[SH_W-1:0];
    end

    // addresses and pixel index
    logic [SH_W+SW_W-1:0]  ysw;
    logic [SH_W+SW_W-1:0]  hsw;
    logic [ROW_W+DW_W-1:0] rdw;
    logic [SH_W+SW_W:0]    ysum;
    logic [POS_W:0]        vusum;
    logic [ROW_W+DW_W:0]   psum;
    logic [SW_W-1:0]       sx_even;
    logic [ADDR_W-1:0]     yaddr_reg;
    logic [ADDR_W-1:0]     vuaddr_reg;
    logic [PIX_W-1:0]      pix_reg;

    assign sx_even = {sx_reg[SW_W-1:1], 1'b0};
    assign ysw     = sy_reg * eff_sw;
    assign hsw     = (sy_reg >> 1) * eff_sw;
    assign rdw     = row_reg * eff_dw;
    assign ysum    = {1'b0, ysw} + (SH_W + SW_W + 1)'(sx_reg);
    assign vusum   = (POS_W + 1)'(area_reg) + (POS_W + 1)'(hsw) + (POS_W + 1)'(sx_even);
    assign psum    = {1'b0, rdw} + (ROW_W + DW_W + 1)'(col_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.addr_calc)
        begin
            yaddr_reg  <= ADDR_W'(ysum);
            vuaddr_reg <= ADDR_W'(vusum);
            pix_reg    <= PIX_W'(psum);
        end
    end

    // frame store
    logic [BYTE_W-1:0] mem [n21rs_pkg::STORE_DEPTH];
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rdata_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            n21rs_pkg::RD_SEL_Y: rd_addr = yaddr_reg;
            n21rs_pkg::RD_SEL_V: rd_addr = vuaddr_reg;
            n21rs_pkg::RD_SEL_U: rd_addr = vuaddr_reg + 1'b1;
            default:             rd_addr = yaddr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
            mem[load_pos_reg[ADDR_W-1:0]] <= byte_reg;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
    end

    // color conversion
    logic [7:0]              y_reg;
    logic [7:0]              v_reg;
    logic [7:0]              y2_reg;
    logic signed [8:0]       vs;
    logic signed [8:0]       us;
    logic signed [ACC_W-1:0] p_rv_reg, p_gu_reg, p_gv_reg, p_bu_reg;
    logic signed [ACC_W-1:0] y_ext;
    logic signed [ACC_W-1:0] acc_r, acc_g, acc_b;
    logic [CH_W-1:0]         red_reg, green_reg, blue_reg;

    assign vs = $signed({1'b0, v_reg}) - 9'sd128;
    assign us = $signed({1'b0, rdata_reg}) - 9'sd128;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_y)
            y_reg <= rdata_reg;
        if (cmd.cap_v)
            v_reg <= rdata_reg;
        if (cmd.prod)
        begin
            y2_reg   <= y_reg;
            p_rv_reg <= ACC_W'(n21rs_pkg::COEF_RV) * ACC_W'(vs);
            p_gu_reg <= ACC_W'(n21rs_pkg::COEF_GU) * ACC_W'(us);
            p_gv_reg <= ACC_W'(n21rs_pkg::COEF_GV) * ACC_W'(vs);
            p_bu_reg <= ACC_W'(n21rs_pkg::COEF_BU) * ACC_W'(us);
        end
    end

    assign y_ext = $signed(ACC_W'({y2_reg, 16'h0000}));
    assign acc_r = y_ext + p_rv_reg;
    assign acc_g = y_ext - p_gu_reg - p_gv_reg;
    assign acc_b = y_ext + p_bu_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.conv)
        begin
            red_reg   <= minus_mean(to_channel(acc_r), mean_red_reg);
            green_reg <= minus_mean(to_channel(acc_g), mean_green_reg);
            blue_reg  <= minus_mean(to_channel(acc_b), mean_blue_reg);
        end
    end

    // output payload
    logic [TDATA_W-1:0] tdata_reg;
    logic               tlast_reg;
    logic               tuser_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            tdata_reg <= {{PAD_W{1'b0}}, blue_reg, green_reg, red_reg, pix_reg};
            tlast_reg <= last;
            tuser_reg <= 1'b0;
        end
        else if (cmd.emit_zero)
        begin
            tdata_reg <= '0;
            tlast_reg <= 1'b0;
            tuser_reg <= 1'b1;
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tlast = tlast_reg;
    assign m_tuser = tuser_reg;

    assign sts.action     = action_reg;
    assign sts.incomplete = (load_pos_reg < fsize_reg);
    assign sts.last       = last;
    assign sts.div_done   = div_done;

endmodule

### hdl/n21rs_ctrl.sv
// controller state machine sequencing loads and pixel conversions
module n21rs_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  n21rs_pkg::n21rs_sts_t  sts,
    output n21rs_pkg::n21rs_cmd_t  cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] ST_CHECK    = 4'd1;
    localparam logic [ST_W-1:0] ST_DIVX     = 4'd2;
    localparam logic [ST_W-1:0] ST_DIVY     = 4'd3;
    localparam logic [ST_W-1:0] ST_ADDR     = 4'd4;
    localparam logic [ST_W-1:0] ST_RD_Y     = 4'd5;
    localparam logic [ST_W-1:0] ST_RD_V     = 4'd6;
    localparam logic [ST_W-1:0] ST_RD_U     = 4'd7;
    localparam logic [ST_W-1:0] ST_PROD     = 4'd8;
    localparam logic [ST_W-1:0] ST_CONV     = 4'd9;
    localparam logic [ST_W-1:0] ST_EMIT     = 4'd10;
    localparam logic [ST_W-1:0] ST_EMIT_INC = 4'd11;

    logic [ST_W-1:0] state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        cmd           = '0;
        cmd.rd_sel    = n21rs_pkg::RD_SEL_Y;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.action)
                begin
                    cmd.load_write = sts.incomplete;
                    state_next     = ST_IDLE;
                end
                else if (sts.incomplete)
                begin
                    state_next = ST_EMIT_INC;
                end
                else
                begin
                    cmd.wrap       = 1'b1;
                    cmd.divx_start = 1'b1;
                    state_next     = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_sx     = 1'b1;
                    cmd.divy_start = 1'b1;
                    state_next     = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_sy = 1'b1;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.addr_calc = 1'b1;
                state_next    = ST_RD_Y;
            end
            ST_RD_Y:
            begin
                cmd.rd_sel = n21rs_pkg::RD_SEL_Y;
                state_next = ST_RD_V;
            end
            ST_RD_V:
            begin
                cmd.rd_sel = n21rs_pkg::RD_SEL_V;
                cmd.cap_y  = 1'b1;
                state_next = ST_RD_U;
            end
            ST_RD_U:
            begin
                cmd.rd_sel = n21rs_pkg::RD_SEL_U;
                cmd.cap_v  = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.conv   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_INC:
            begin
                if (slot_free)
                begin
                    cmd.emit_zero = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

### test/tb_top.sv
// testbench for the nv21 resize to planar rgb block: directed table, random frames, checking
`timescale 1ns / 1ps

module tb_top;

    import n21rs_pkg::*;

    localparam int Q16_RV = 89831;
    localparam int Q16_GU = 45744;
    localparam int Q16_GV = 46080;
    localparam int Q16_BU = 113538;

    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1100;

    typedef enum logic {ACT_LOAD = 1'b0, ACT_CONVERT = 1'b1} action_e;
    typedef enum logic [1:0] {ROW_WRITE, ROW_LOAD, ROW_CONVERT} row_kind_e;

    typedef struct packed {
        logic [PIX_W-1:0] pix_index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             last_pix;
        logic             incomplete;
    } pixel_t;

    typedef struct {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  value;
        bit                     typed;
        pixel_t                 want;
    } row_t;

    localparam pixel_t NOT_LOADED = '{pix_index: '0, red: '0, green: '0, blue: '0,
                                      last_pix: 1'b0, incomplete: 1'b1};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [BYTE_W-1:0]      s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    bit [7:0]               frame_copy [STORE_DEPTH];
    logic [CFG_SW_W-1:0]    reg_src_w = 10'd640;
    logic [CFG_SH_W-1:0]    reg_src_h = 9'd480;
    logic [CFG_DW_W-1:0]    reg_dst_w = 10'd224;
    logic [CFG_DH_W-1:0]    reg_dst_h = 9'd224;
    logic [MEAN_W-1:0]      mean_r = '0;
    logic [MEAN_W-1:0]      mean_g = '0;
    logic [MEAN_W-1:0]      mean_b = '0;
    int unsigned            load_pos = 0;
    int unsigned            out_row = 0;
    int unsigned            out_col = 0;

    pixel_t                 pending_pixels [$];
    row_t                   plan [$];
    bit                     frame_done;
    bit                     calm = 1'b0;
    int unsigned            useful_items = 0;
    int unsigned            mismatches = 0;
    int unsigned            holdoff_requests = 0;
    int unsigned            holdoffs_granted = 0;
    int unsigned            hold_left = 0;

    nv21_resize_to_planar_rgb_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned eff_src_w();
        return clamp_size(reg_src_w, 2, MAX_SRC_WIDTH) & ~32'd1;
    endfunction

    function automatic int unsigned eff_src_h();
        return clamp_size(reg_src_h, 2, MAX_SRC_HEIGHT) & ~32'd1;
    endfunction

    function automatic int unsigned eff_dst_w();
        return clamp_size(reg_dst_w, 1, MAX_DST_WIDTH);
    endfunction

    function automatic int unsigned eff_dst_h();
        return clamp_size(reg_dst_h, 1, MAX_DST_HEIGHT);
    endfunction

    function automatic int unsigned frame_bytes();
        int unsigned area;
        area = eff_src_w() * eff_src_h();
        return area + area / 2;
    endfunction

    // floor of a q16 sum, clamped to a byte, then q8.8 minus the mean
    function automatic logic [CH_W-1:0] rgb_channel(int acc, logic [MEAN_W-1:0] mean);
        int q;
        q = acc >>> 16;
        if (q < 0)
            q = 0;
        if (q > 255)
            q = 255;
        q = q * 256 - int'(mean);
        return q[CH_W-1:0];
    endfunction

    // returns 1 when the item yields a pixel
    function automatic bit advance_resizer(action_e act, logic [7:0] data_byte, output pixel_t pix);
        int unsigned sw, sh, dw, dh, sx, sy, vu_addr;
        int yv, uv, vv;
        pix = '0;
        if (act == ACT_LOAD)
        begin
            if (load_pos < frame_bytes())
            begin
                frame_copy[load_pos] = data_byte;
                load_pos++;
                useful_items++;
            end
            return 1'b0;
        end
        useful_items++;
        if (load_pos < frame_bytes())
        begin
            pix.incomplete = 1'b1;
            return 1'b1;
        end
        sw = eff_src_w();
        sh = eff_src_h();
        dw = eff_dst_w();
        dh = eff_dst_h();
        if (out_row >= dh || out_col >= dw)
        begin
            out_row = 0;
            out_col = 0;
        end
        sx = (out_col * sw) / dw;
        sy = (out_row * sh) / dh;
        yv = int'(frame_copy[sy * sw + sx]);
        vu_addr = sw * sh + (sy >> 1) * sw + (sx & ~32'd1);
        vv = int'(frame_copy[vu_addr]) - 128;
        uv = int'(frame_copy[vu_addr + 1]) - 128;
        pix.pix_index = PIX_W'(out_row * dw + out_col);
        pix.red       = rgb_channel(yv * 65536 + Q16_RV * vv, mean_r);
        pix.green     = rgb_channel(yv * 65536 - Q16_GU * uv - Q16_GV * vv, mean_g);
        pix.blue      = rgb_channel(yv * 65536 + Q16_BU * uv, mean_b);
        pix.last_pix  = (out_row == dh - 1) && (out_col == dw - 1);
        if (pix.last_pix)
        begin
            out_row = 0;
            out_col = 0;
            load_pos = 0;
            frame_done = 1'b1;
        end
        else if (out_col + 1 >= dw)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
        return 1'b1;
    endfunction

    function automatic pixel_t px(int idx, int r, int g, int b, bit last_one);
        pixel_t p;
        p = '0;
        p.pix_index = idx[PIX_W-1:0];
        p.red = r[CH_W-1:0];
        p.green = g[CH_W-1:0];
        p.blue = b[CH_W-1:0];
        p.last_pix = last_one;
        return p;
    endfunction

    function automatic void add_row(row_kind_e kind, logic [CFG_IDX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] value, bit typed, pixel_t want);
        row_t r;
        r.kind = kind;
        r.index = idx;
        r.value = value;
        r.typed = typed;
        r.want = want;
        plan.push_back(r);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_noise(int unsigned v, int unsigned w);
        return CFG_DATA_W'(($urandom << w) | v);
    endfunction

    function automatic logic [MEAN_W-1:0] pick_mean();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return MEAN_W'($urandom);
        endcase
    endfunction

    function automatic void build_plan();
        logic [7:0] partial [8] = '{8'h10, 8'heb, 8'h80, 8'h55, 8'h01, 8'hfe, 8'h00, 8'hff};
        // convert right after reset, nothing loaded
        add_row(ROW_CONVERT, '0, 16'h00ff, 1'b1, NOT_LOADED);
        add_row(ROW_WRITE, REG_SRC_WIDTH, 16'd2, 1'b0, '0);
        add_row(ROW_WRITE, REG_SRC_HEIGHT, 16'd2, 1'b0, '0);
        add_row(ROW_WRITE, REG_DST_WIDTH, 16'd2, 1'b0, '0);
        add_row(ROW_WRITE, REG_DST_HEIGHT, 16'd2, 1'b0, '0);
        add_row(ROW_WRITE, REG_MEAN_RED, 16'hffff, 1'b0, '0);
        add_row(ROW_WRITE, REG_MEAN_GREEN, 16'h0000, 1'b0, '0);
        add_row(ROW_WRITE, REG_MEAN_BLUE, 16'h8000, 1'b0, '0);
        add_row(ROW_LOAD, '0, 16'd255, 1'b0, '0);
        add_row(ROW_LOAD, '0, 16'd0, 1'b0, '0);
        add_row(ROW_LOAD, '0, 16'd255, 1'b0, '0);
        // half-loaded frame
        add_row(ROW_CONVERT, '0, 16'h0000, 1'b1, NOT_LOADED);
        add_row(ROW_LOAD, '0, 16'd0, 1'b0, '0);
        add_row(ROW_LOAD, '0, 16'd128, 1'b0, '0);
        add_row(ROW_LOAD, '0, 16'd128, 1'b0, '0);
        // surplus byte is dropped
        add_row(ROW_LOAD, '0, 16'h004d, 1'b0, '0);
        // neutral chroma: channels equal luma
        add_row(ROW_CONVERT, '0, 16'h00ff, 1'b1, px(0, -255, 65280, 32512, 1'b0));
        add_row(ROW_CONVERT, '0, 16'h0000, 1'b1, px(1, -65535, 0, -32768, 1'b0));
        add_row(ROW_CONVERT, '0, 16'h00ff, 1'b1, px(2, -255, 65280, 32512, 1'b0));
        add_row(ROW_CONVERT, '0, 16'h0000, 1'b1, px(3, -65535, 0, -32768, 1'b1));
        // frame consumed, must be reloaded
        add_row(ROW_CONVERT, '0, 16'h00aa, 1'b1, NOT_LOADED);
        // out of range source height, partial load then frame shrinks below it
        add_row(ROW_WRITE, REG_SRC_WIDTH, 16'd4, 1'b0, '0);
        add_row(ROW_WRITE, REG_SRC_HEIGHT, 16'd0, 1'b0, '0);
        add_row(ROW_WRITE, REG_DST_WIDTH, 16'd3, 1'b0, '0);
        add_row(ROW_WRITE, REG_DST_HEIGHT, 16'd3, 1'b0, '0);
        add_row(ROW_WRITE, REG_MEAN_RED, 16'h0000, 1'b0, '0);
        add_row(ROW_WRITE, REG_MEAN_BLUE, 16'h0000, 1'b0, '0);
        foreach (partial[i])
            add_row(ROW_LOAD, '0, {8'h00, partial[i]}, 1'b0, '0);
        // odd width rounds down to 2
        add_row(ROW_WRITE, REG_SRC_WIDTH, 16'd3, 1'b0, '0);
        add_row(ROW_CONVERT, '0, 16'h0055, 1'b0, '0);
        add_row(ROW_CONVERT, '0, 16'h0000, 1'b0, '0);
        // width 0 clamps to 1, leaving the column out of range
        add_row(ROW_WRITE, REG_DST_WIDTH, 16'd0, 1'b0, '0);
        add_row(ROW_CONVERT, '0, 16'h0000, 1'b0, '0);
        add_row(ROW_CONVERT, '0, 16'h00ff, 1'b0, '0);
        add_row(ROW_CONVERT, '0, 16'h0000, 1'b0, '0);
    endfunction

    task automatic report(string what, longint unsigned got, longint unsigned want);
        if (mismatches < 100)
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatches++;
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pending_pixels.size() == 0)
            report("pixel with nothing pending", m_tdata[PIX_W-1:0], 0);
        else
        begin
            want = pending_pixels.pop_front();
            if (m_tdata[18:0] !== want.pix_index)
                report("pixel_index", m_tdata[18:0], want.pix_index);
            if (m_tdata[35:19] !== want.red)
                report("red_value", m_tdata[35:19], want.red);
            if (m_tdata[52:36] !== want.green)
                report("green_value", m_tdata[52:36], want.green);
            if (m_tdata[69:53] !== want.blue)
                report("blue_value", m_tdata[69:53], want.blue);
            if (m_tlast !== want.last_pix)
                report("last_pixel", m_tlast, want.last_pix);
            if (m_tuser !== want.incomplete)
                report("frame_incomplete", m_tuser, want.incomplete);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_pixel();
    end

    // receiver: random back-pressure plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holdoff_requests != holdoffs_granted)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            holdoffs_granted <= holdoff_requests;
        end
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 20);
    end

    task automatic send_item(action_e act, logic [7:0] data_byte);
        pixel_t pix;
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= data_byte;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (advance_resizer(act, data_byte, pix))
            pending_pixels.push_back(pix);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  reg_src_w = data[CFG_SW_W-1:0];
            REG_SRC_HEIGHT: reg_src_h = data[CFG_SH_W-1:0];
            REG_DST_WIDTH:  reg_dst_w = data[CFG_DW_W-1:0];
            REG_DST_HEIGHT: reg_dst_h = data[CFG_DH_W-1:0];
            REG_MEAN_RED:   mean_r = data[MEAN_W-1:0];
            REG_MEAN_GREEN: mean_g = data[MEAN_W-1:0];
            REG_MEAN_BLUE:  mean_b = data[MEAN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // let every pixel come out, then allow a trailing load to finish
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_extreme_frame(int unsigned sw, int unsigned sh, int unsigned dw,
                                     int unsigned dh, bit squeeze);
        drain_block();
        write_reg(REG_SRC_WIDTH, with_noise(sw, CFG_SW_W));
        write_reg(REG_SRC_HEIGHT, with_noise(sh, CFG_SH_W));
        write_reg(REG_DST_WIDTH, with_noise(dw, CFG_DW_W));
        write_reg(REG_DST_HEIGHT, with_noise(dh, CFG_DH_W));
        write_reg(REG_MEAN_RED, pick_mean());
        write_reg(REG_MEAN_GREEN, pick_mean());
        write_reg(REG_MEAN_BLUE, pick_mean());
        while (load_pos < frame_bytes())
            send_item(ACT_LOAD, 8'($urandom));
        if (squeeze)
            holdoff_requests <= holdoff_requests + 1;
        frame_done = 1'b0;
        while (!frame_done)
            send_item(ACT_CONVERT, 8'($urandom));
    endtask

    task automatic run_random_phase();
        int unsigned frames;
        bit cut;
        drain_block();
        write_reg(REG_SRC_WIDTH, with_noise(($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 3) : 2 * $urandom_range(1, 4), CFG_SW_W));
        write_reg(REG_SRC_HEIGHT, with_noise(($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 3) : 2 * $urandom_range(1, 2), CFG_SH_W));
        write_reg(REG_DST_WIDTH, with_noise(($urandom_range(0, 9) == 0) ?
                  0 : $urandom_range(1, 6), CFG_DW_W));
        write_reg(REG_DST_HEIGHT, with_noise(($urandom_range(0, 9) == 0) ?
                  0 : $urandom_range(1, 5), CFG_DH_W));
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_MEAN_RED, pick_mean());
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_MEAN_GREEN, pick_mean());
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_MEAN_BLUE, pick_mean());
        cut = 1'b0;
        frames = $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(10, 30))
                send_item(action_e'($urandom_range(0, 1)), 8'($urandom));
        for (int f = 0; f < frames && !cut; f++)
        begin
            while (load_pos < frame_bytes() && !cut)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_item(ACT_CONVERT, 8'($urandom));
                send_item(ACT_LOAD, 8'($urandom));
                cut = ($urandom_range(0, 299) == 0);
            end
            if ($urandom_range(0, 7) == 0)
                send_item(ACT_LOAD, 8'($urandom));
            frame_done = 1'b0;
            while (!frame_done && !cut)
            begin
                send_item(ACT_CONVERT, 8'($urandom));
                cut = ($urandom_range(0, 149) == 0);
            end
            if (frame_done && $urandom_range(0, 5) == 0)
                send_item(ACT_CONVERT, 8'($urandom));
        end
    endtask

    // ends the run when no transfer happens for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned first;
        build_plan();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_WRITE:
                begin
                    drain_block();
                    write_reg(plan[i].index, plan[i].value);
                end
                ROW_LOAD:
                    send_item(ACT_LOAD, plan[i].value[7:0]);
                default:
                begin
                    send_item(ACT_CONVERT, plan[i].value[7:0]);
                    if (plan[i].typed)
                        pending_pixels[$] = plan[i].want;
                end
            endcase
        end
        // widest source and target, output held off while converts keep coming
        run_extreme_frame(640, 1, 1023, 1, 1'b1);
        first = useful_items;
        while (useful_items - first < RANDOM_ITEMS)
            run_random_phase();
        // tallest source and target, no idling on either side
        calm <= 1'b1;
        run_extreme_frame(2, 511, 1, 480, 1'b0);
        drain_block();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
